// ----- hw/rtl/fds_pkg.sv -----
// Shared types and constants for the FAT16 directory entry scanner.
// No dependencies; imported by fds_judge, fds_fifo and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fds_pkg;

  localparam int ENTRY_LEN = 32;
  localparam int COUNT_W   = 11;
  localparam int POS_W     = 5;

  // Directory entry markers and attribute bits
  localparam logic [7:0] MARK_END       = 8'h00;
  localparam logic [7:0] MARK_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME    = 8'h08;
  localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
  localparam logic [7:0] SPACE_CHAR     = 8'h20;

  localparam logic [POS_W-1:0]   POS_LAST         = 5'd31;
  localparam logic [COUNT_W-1:0] FILE_LIMIT_RESET = 11'd64;

  // Result kinds
  localparam logic KIND_FILE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Result queue geometry
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_LW    = 4;

  // One complete 32-byte entry, byte 0 in the lowest position
  typedef logic [ENTRY_LEN-1:0][7:0] entry_t;

  // Decoded view of a complete entry
  typedef struct packed {
    logic        is_end;
    logic        is_skip;
    logic [63:0] name;
    logic [23:0] ext;
    logic [15:0] cluster;
    logic [31:0] size;
  } file_info_t;

  // One result item
  typedef struct packed {
    logic               kind;
    logic               last;
    logic [63:0]        file_name;
    logic [23:0]        file_ext;
    logic [15:0]        first_cluster;
    logic [31:0]        size_bytes;
    logic [COUNT_W-1:0] file_count;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fds_judge.sv -----
// Combinational decode of one complete directory entry: classification,
// name/extension space trimming and field extraction. Uses fds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fds_judge
  import fds_pkg::*;
(
  input  var entry_t     entry,
  output var file_info_t info
);

  logic [7:0] attr;
  logic       seen_name;
  logic       seen_ext;

  always_comb begin
    attr = entry[11];

    // Classification
    info.is_end  = (entry[0] == MARK_END);
    info.is_skip = (entry[0] == MARK_DELETED) || (attr == ATTR_LONG_NAME) ||
                   ((attr & (ATTR_VOLUME | ATTR_DIRECTORY)) != 8'h00);

    // Name: zero the run of spaces at the tail
    seen_name = 1'b0;
    info.name = '0;
    for (int j = 7; j >= 0; j--) begin
      seen_name = seen_name | (entry[j] != SPACE_CHAR);
      info.name[j*8 +: 8] = seen_name ? entry[j] : 8'h00;
    end

    // Extension: same trimming over bytes 8..10
    seen_ext = 1'b0;
    info.ext = '0;
    for (int j = 2; j >= 0; j--) begin
      seen_ext = seen_ext | (entry[8+j] != SPACE_CHAR);
      info.ext[j*8 +: 8] = seen_ext ? entry[8+j] : 8'h00;
    end

    // Little-endian words
    info.cluster = {entry[27], entry[26]};
    info.size    = {entry[31], entry[30], entry[29], entry[28]};
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fds_fifo.sv -----
// Result queue: takes up to two results per cycle, delivers one per cycle
// to the output stream while out_ready is high. Uses fds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fds_fifo
  import fds_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push0,
  input  var  result_t push0_data,
  input  wire logic    push1,
  input  var  result_t push1_data,
  output var  logic    room,
  output var  logic    out_valid,
  input  wire logic    out_ready,
  output var  result_t out_data
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_LW-1:0]   level;
  logic [FIFO_LW-1:0]   level_next;
  logic [FIFO_AW-1:0]   wr_ptr_next;
  logic                 pop;
  logic [1:0]           push_n;

  always_comb begin
    pop         = out_valid && out_ready;
    push_n      = {1'b0, push0} + {1'b0, push1};
    wr_ptr_next = wr_ptr + FIFO_AW'(push_n);
    level_next  = level + FIFO_LW'(push_n) - FIFO_LW'(pop);
  end

  // Storage; push1 only ever comes with push0
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= push0_data;
    end
    if (push1) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push1_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      level <= level_next;
    end
  end

  // Room for the item in flight plus a new one, two results each
  assign room      = (level <= FIFO_LW'(FIFO_DEPTH - 4));
  assign out_valid = (level != '0);
  assign out_data  = mem[rd_ptr];

endmodule

`default_nettype wire

// ----- hw/rtl/fat16_directory_entry_scanner.sv -----
// FAT16 root-directory scanner. Bytes of the root-directory region enter on
// s_axis one per cycle (tlast marks the region's last byte) and are cut into
// 32-byte entries. Each completed entry is judged: a 0x00 first byte ends
// the scan, deleted, long-name, volume and directory entries are skipped,
// and other entries are reported as file results until the file limit is
// reached. The region's last byte adds a closing result with the count and
// re-arms the scanner. A byte is accepted every cycle while s_axis_tready is
// high; results are registered via the input register and result queue.
// s_axis_tready is low during reset and otherwise drops only while the
// eight-entry result queue holds more than four results (output stall).
// Uses fds_pkg, fds_judge and fds_fifo.
`timescale 1ns / 1ps
`default_nettype none

module fat16_directory_entry_scanner
  import fds_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream
  input  wire logic         s_axis_tvalid,
  output var  logic         s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tlast,   // final_byte
  // Result stream
  output var  logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [63:0] file_name, [87:64] file_ext, [103:88] first cluster,
  // [135:104] size in bytes, [146:136] file_count, [151:147] zero
  output var  logic [151:0] m_axis_tdata,
  output var  logic         m_axis_tlast,   // last
  output var  logic         m_axis_tuser,   // kind
  // Configuration
  input  wire logic         cfg_wr_en,
  input  wire logic [10:0]  cfg_wr_data     // file limit
);

  // Input register
  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_fin;

  // Scan state
  logic [7:0]         entry_mem [ENTRY_LEN-1];
  logic [POS_W-1:0]   byte_position;
  logic [COUNT_W-1:0] files_found;
  logic [COUNT_W-1:0] files_found_next;
  logic               scan_ended;
  logic               scan_ended_next;
  logic [COUNT_W-1:0] file_limit;

  entry_t             entry;
  file_info_t         info;
  logic               at_last;
  logic               file_hit;
  logic               end_hit;
  logic               push0;
  logic               push1;
  result_t            push0_data;
  result_t            push1_data;
  result_t            done_res;
  result_t            file_res;
  result_t            out_res;
  logic               room;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      file_limit <= FILE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      file_limit <= cfg_wr_data;
    end
  end

  // Input register
  assign s_axis_tready = room && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_fin  <= s_axis_tlast;
    end
  end

  // Complete entry: stored bytes plus the byte now in the input register
  always_comb begin
    for (int i = 0; i < ENTRY_LEN - 1; i++) begin
      entry[i] = entry_mem[i];
    end
    entry[ENTRY_LEN-1] = in_byte;
  end

  fds_judge u_judge (
    .entry (entry),
    .info  (info)
  );

  // Judgment and result selection
  always_comb begin
    at_last  = in_valid && (byte_position == POS_LAST);
    file_hit = at_last && !scan_ended && !info.is_end && !info.is_skip &&
               (files_found < file_limit);
    end_hit  = at_last && !scan_ended && info.is_end;

    files_found_next = files_found + COUNT_W'(file_hit);
    scan_ended_next  = scan_ended | end_hit;

    file_res.kind          = KIND_FILE;
    file_res.last          = !in_fin;
    file_res.file_name     = info.name;
    file_res.file_ext      = info.ext;
    file_res.first_cluster = info.cluster;
    file_res.size_bytes    = info.size;
    file_res.file_count    = files_found_next;

    done_res               = '0;
    done_res.kind          = KIND_DONE;
    done_res.last          = 1'b1;
    done_res.file_count    = files_found_next;

    push0      = file_hit || (in_valid && in_fin);
    push0_data = file_hit ? file_res : done_res;
    push1      = file_hit && in_fin;
    push1_data = done_res;
  end

  // Entry byte capture; byte 31 is used straight from the input register
  always_ff @(posedge clk) begin
    if (in_valid && (byte_position != POS_LAST)) begin
      entry_mem[byte_position] <= in_byte;
    end
  end

  // Position, count and end flag; the last byte of the region re-arms
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      files_found   <= '0;
      scan_ended    <= 1'b0;
    end else if (in_valid) begin
      if (in_fin) begin
        byte_position <= '0;
        files_found   <= '0;
        scan_ended    <= 1'b0;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        files_found   <= files_found_next;
        scan_ended    <= scan_ended_next;
      end
    end
  end

  fds_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (push0),
    .push0_data (push0_data),
    .push1      (push1),
    .push1_data (push1_data),
    .room       (room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  // Output packing
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = {5'b0, out_res.file_count, out_res.size_bytes,
                         out_res.first_cluster, out_res.file_ext,
                         out_res.file_name};

endmodule

`default_nettype wire
